FILE: hw/rtl/sfla_pkg.sv
// shared types, constants and register codes for the slab free-list allocator
// no dependencies; every other rtl file of the block refers to this package
package sfla_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int LINK_W    = SLOT_W + 1;
	localparam int CNT_W     = 11;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_SLOTS);

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// register indexes, taken from paddr[2]
	localparam logic REG_BLOCK_SLOTS = 1'b0;
	localparam logic REG_MAX_BLOCKS  = 1'b1;

	localparam logic [CNT_W-1:0] BLOCK_SLOTS_RST = 11'd16;
	localparam logic [CNT_W-1:0] MAX_BLOCKS_RST  = 11'd64;

	typedef struct packed {
		logic              op;
		logic [SLOT_W-1:0] slot;
		logic              slot_null;
	} sfla_in_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] granted_slot;
		logic [CNT_W-1:0]  free_slots;
		logic [CNT_W-1:0]  total_slots;
		logic [CNT_W-1:0]  blocks_used;
	} sfla_out_t;

	typedef struct packed {
		logic [CNT_W-1:0] block_slots;
		logic [CNT_W-1:0] max_blocks;
	} sfla_cfg_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [LINK_W-1:0] wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} sfla_ram_req_t;

endpackage

FILE: hw/rtl/sfla_cfg_regs.sv
// apb-style configuration registers: block_slots and max_blocks
// depends on sfla_pkg
module sfla_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfla_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfla_pkg::DATA_W-1:0]  pwdata,
	output logic [sfla_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output sfla_pkg::sfla_cfg_t          cfg
);

	logic [sfla_pkg::CNT_W-1:0] block_slots_q;
	logic [sfla_pkg::CNT_W-1:0] max_blocks_q;
	logic                       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_slots_q <= sfla_pkg::BLOCK_SLOTS_RST;
			max_blocks_q  <= sfla_pkg::MAX_BLOCKS_RST;
		end else if (wr_en) begin
			case (paddr[2])
				sfla_pkg::REG_BLOCK_SLOTS: block_slots_q <= pwdata[sfla_pkg::CNT_W-1:0];
				sfla_pkg::REG_MAX_BLOCKS:  max_blocks_q  <= pwdata[sfla_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			sfla_pkg::REG_BLOCK_SLOTS:
				prdata = {{(sfla_pkg::DATA_W-sfla_pkg::CNT_W){1'b0}}, block_slots_q};
			sfla_pkg::REG_MAX_BLOCKS:
				prdata = {{(sfla_pkg::DATA_W-sfla_pkg::CNT_W){1'b0}}, max_blocks_q};
			default:
				prdata = '0;
		endcase
	end

	assign cfg.block_slots = block_slots_q;
	assign cfg.max_blocks  = max_blocks_q;

endmodule

FILE: hw/rtl/sfla_link_ram.sv
// next-pointer memory of the free list, one write and one registered read port
// depends on sfla_pkg
module sfla_link_ram (
	input  logic                         clk,
	input  sfla_pkg::sfla_ram_req_t      req,
	output logic [sfla_pkg::LINK_W-1:0]  rdata
);

	logic [sfla_pkg::LINK_W-1:0] mem [sfla_pkg::MAX_SLOTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

FILE: hw/rtl/sfla_ctrl.sv
// allocator sequencer: pop, push, block growth walk and the output register
// depends on sfla_pkg; drives sfla_link_ram through a request struct
module sfla_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfla_pkg::sfla_cfg_t          cfg,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  sfla_pkg::sfla_in_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output sfla_pkg::sfla_out_t          out_data,
	output sfla_pkg::sfla_ram_req_t      ram_req,
	input  logic [sfla_pkg::LINK_W-1:0]  ram_rdata
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_GROW = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	localparam int CW = sfla_pkg::CNT_W;
	localparam int SW = sfla_pkg::SLOT_W;
	localparam int LW = sfla_pkg::LINK_W;

	logic [1:0]    state_q, state_d;
	logic [LW-1:0] head_q, head_d;
	logic [CW-1:0] free_q, free_d;
	logic [CW-1:0] cap_q, cap_d;
	logic [CW-1:0] blk_q, blk_d;
	logic [CW-1:0] size_q, size_d;
	logic [CW-1:0] walk_q, walk_d;
	logic [SW-1:0] grant_q, grant_d;
	logic          out_valid_q, out_valid_d;
	sfla_pkg::sfla_out_t out_q, out_d;
	sfla_pkg::sfla_out_t res_q, res_d;

	sfla_pkg::sfla_out_t res;
	logic          emit;
	logic          out_free;
	logic          out_load;
	logic [CW-1:0] size_eff;
	logic [CW:0]   grow_sum;
	logic          grow_ok;
	logic          head_valid;
	logic [CW-1:0] free_inc;
	logic [CW-1:0] free_dec;
	logic [CW-1:0] grow_addr;
	logic          grow_last;
	logic [CW:0]   free_sum;
	logic [CW-1:0] free_grown;

	assign out_free   = !out_valid_q || !out_stall;
	assign size_eff   = (cfg.block_slots == '0) ? CW'(1) : cfg.block_slots;
	assign grow_sum   = {1'b0, cap_q} + {1'b0, size_eff};
	assign grow_ok    = (blk_q < cfg.max_blocks) && (grow_sum <= (CW+1)'(sfla_pkg::MAX_SLOTS));
	assign head_valid = head_q < sfla_pkg::LINK_NULL;
	assign free_inc   = (free_q == sfla_pkg::COUNT_MAX) ? free_q : free_q + CW'(1);
	assign free_dec   = (free_q == '0) ? free_q : free_q - CW'(1);
	assign grow_addr  = cap_q + walk_q;
	assign grow_last  = walk_q == size_q - CW'(1);
	assign free_sum   = {1'b0, free_q} + {1'b0, size_q};
	// saturate, then take the popped slot off (always at least one slot)
	assign free_grown = (free_sum > {1'b0, sfla_pkg::COUNT_MAX}) ?
		sfla_pkg::COUNT_MAX - CW'(1) : free_sum[CW-1:0] - CW'(1);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		free_d   = free_q;
		cap_d    = cap_q;
		blk_d    = blk_q;
		size_d   = size_q;
		walk_d   = walk_q;
		grant_d  = grant_q;
		res_d    = res_q;
		out_d    = out_q;
		emit     = 1'b0;
		ram_req  = '0;
		res.ok           = 1'b0;
		res.granted_slot = '0;
		res.free_slots   = free_q;
		res.total_slots  = cap_q;
		res.blocks_used  = blk_q;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.op == sfla_pkg::OP_ALLOC) begin
						if (head_valid) begin
							ram_req.re    = 1'b1;
							ram_req.raddr = head_q[SW-1:0];
							grant_d       = head_q[SW-1:0];
							state_d       = ST_POP;
						end else if (grow_ok) begin
							size_d  = size_eff;
							walk_d  = '0;
							state_d = ST_GROW;
						end else begin
							emit = 1'b1;
						end
					end else if (in_data.slot_null) begin
						res.ok = 1'b1;
						emit   = 1'b1;
					end else if ({1'b0, in_data.slot} < cap_q) begin
						ram_req.we     = 1'b1;
						ram_req.waddr  = in_data.slot;
						ram_req.wdata  = head_q;
						head_d         = {1'b0, in_data.slot};
						free_d         = free_inc;
						res.ok         = 1'b1;
						res.free_slots = free_inc;
						emit           = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
			end
			ST_POP: begin
				head_d           = ram_rdata;
				free_d           = free_dec;
				res.ok           = 1'b1;
				res.granted_slot = grant_q;
				res.free_slots   = free_dec;
				emit             = 1'b1;
			end
			ST_GROW: begin
				// thread the new block so the highest index ends up on top
				ram_req.we    = 1'b1;
				ram_req.waddr = grow_addr[SW-1:0];
				ram_req.wdata = (walk_q == '0) ? head_q : LW'(grow_addr - CW'(1));
				walk_d        = walk_q + CW'(1);
				if (grow_last) begin
					head_d = (size_q == CW'(1)) ? head_q : LW'(grow_addr - CW'(1));
					cap_d  = grow_addr + CW'(1);
					blk_d  = blk_q + CW'(1);
					free_d = free_grown;
					res.ok           = 1'b1;
					res.granted_slot = grow_addr[SW-1:0];
					res.free_slots   = free_grown;
					res.total_slots  = grow_addr + CW'(1);
					res.blocks_used  = blk_q + CW'(1);
					emit             = 1'b1;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					out_d   = res_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		if (emit) begin
			if (out_free) begin
				out_d   = res;
				state_d = ST_IDLE;
			end else begin
				res_d   = res;
				state_d = ST_HOLD;
			end
		end
	end

	assign out_load    = (emit || state_q == ST_HOLD) && out_free;
	assign out_valid_d = out_load || (out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= sfla_pkg::LINK_NULL;
			free_q      <= '0;
			cap_q       <= '0;
			blk_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			free_q      <= free_d;
			cap_q       <= cap_d;
			blk_q       <= blk_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		size_q  <= size_d;
		walk_q  <= walk_d;
		grant_q <= grant_d;
		res_q   <= res_d;
		out_q   <= out_d;
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= sfla_pkg::LINK_NULL)
		else $error("list head beyond the empty marker");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q <= CW'(sfla_pkg::MAX_SLOTS))
		else $error("capacity beyond slot limit");

	a_grow_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_GROW |-> grow_addr < CW'(sfla_pkg::MAX_SLOTS))
		else $error("growth walk left the link memory");

	a_hold_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOLD && out_free |=> state_q == ST_IDLE && out_valid_q)
		else $error("held result not moved to output register");

	a_blk_step: assert property (@(posedge clk) disable iff (!arst_n)
		blk_q != $past(blk_q) |-> blk_q == $past(blk_q) + CW'(1))
		else $error("block count moved by other than one");

endmodule

FILE: hw/rtl/slab_free_list_allocator_core.sv
// top level of the slab free-list allocator: config registers, sequencer, link memory
// depends on sfla_pkg, sfla_cfg_regs, sfla_ctrl and sfla_link_ram
//
// channel   dir  handshake             payload
// in        in   in_valid / in_stall   sfla_in_t  (op, slot, slot_null)
// out       out  out_valid / out_stall sfla_out_t (ok, granted_slot, counts)
// cfg       in   apb psel/penable      block_slots @0x0, max_blocks @0x4
//
// sequence: a free, a null free or a failed allocate is answered from idle, an allocate
//   that pops the head goes through a pop state (registered read of the link memory), an
//   allocate on an empty list writes one link per new slot (block_slots 0 acts as 1)
// reset: counters clear and the head goes to the empty marker; the link memory is not
//   cleared since an entry is always written by growth or a free before it is read
// stalls: results land in an output register; if it is still held when the next result
//   is ready, the sequencer parks it and raises in_stall until the output drains
module slab_free_list_allocator_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// item channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  sfla_pkg::sfla_in_t           in_data,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output sfla_pkg::sfla_out_t          out_data,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfla_pkg::ADDR_W-1:0]  paddr,
	input  logic [sfla_pkg::DATA_W-1:0]  pwdata,
	output logic [sfla_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	// live register values; user holds them steady while an item is in flight, unchecked
	sfla_pkg::sfla_cfg_t     cfg;
	// one write and one read port request per cycle from the sequencer
	sfla_pkg::sfla_ram_req_t ram_req;
	logic [sfla_pkg::LINK_W-1:0] ram_rdata;

	sfla_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: decides pop, push or growth, walks new blocks, owns the output register
	sfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// next-pointer store, one entry per slot
	sfla_link_ram u_link_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule

FILE: dv/slab_free_list_allocator_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of slab_free_list_allocator_core: directed and random alloc/free
// traffic against a scoreboard class that predicts every result; depends on sfla_pkg and the rtl
module slab_free_list_allocator_core_tb;

	localparam int CW = sfla_pkg::CNT_W;
	localparam int SW = sfla_pkg::SLOT_W;
	localparam int LW = sfla_pkg::LINK_W;

	// generous ceiling, several times the slowest legal run
	localparam int CYCLE_LIMIT = 400000;
	// long receiver hold-off so the result register and the parked result both fill
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT    = 22;
	localparam int SLOT_MAX    = sfla_pkg::MAX_SLOTS - 1;

	// free-list predictor plus the queue of results still owed by the block
	class slab_scoreboard;
		logic [LW-1:0]       next_link [sfla_pkg::MAX_SLOTS];
		logic [LW-1:0]       head;
		logic [CW-1:0]       free_cnt;
		logic [CW-1:0]       cap_cnt;
		logic [CW-1:0]       blk_cnt;
		logic [CW-1:0]       blk_size;
		logic [CW-1:0]       blk_limit;
		sfla_pkg::sfla_out_t awaited_results[$];
		// slots handed out and not yet returned, so stimulus can free them exactly once
		int                  held_slots[$];
		int                  errors;

		function new();
			foreach (next_link[i]) next_link[i] = '0;
			head      = sfla_pkg::LINK_NULL;
			free_cnt  = '0;
			cap_cnt   = '0;
			blk_cnt   = '0;
			blk_size  = sfla_pkg::BLOCK_SLOTS_RST;
			blk_limit = sfla_pkg::MAX_BLOCKS_RST;
			errors    = 0;
		endfunction

		function void set_reg(logic idx, logic [CW-1:0] value);
			if (idx == sfla_pkg::REG_BLOCK_SLOTS) begin
				blk_size = value;
			end else begin
				blk_limit = value;
			end
		endfunction

		// thread one new block onto the list, highest index ends up at the head
		function bit add_block();
			int grow_by;
			int idx;
			grow_by = (blk_size == 0) ? 1 : int'(blk_size);
			if (blk_cnt >= blk_limit) return 1'b0;
			if (int'(cap_cnt) + grow_by > sfla_pkg::MAX_SLOTS) return 1'b0;
			for (int i = 0; i < grow_by; i++) begin
				idx = int'(cap_cnt) + i;
				next_link[idx] = head;
				head = LW'(idx);
			end
			cap_cnt = CW'(int'(cap_cnt) + grow_by);
			if (int'(free_cnt) + grow_by > int'(sfla_pkg::COUNT_MAX)) begin
				free_cnt = sfla_pkg::COUNT_MAX;
			end else begin
				free_cnt = CW'(int'(free_cnt) + grow_by);
			end
			blk_cnt++;
			return 1'b1;
		endfunction

		function sfla_pkg::sfla_out_t step_free_list(sfla_pkg::sfla_in_t it);
			sfla_pkg::sfla_out_t r;
			bit have;
			r = '0;
			if (it.op == sfla_pkg::OP_ALLOC) begin
				have = (head != sfla_pkg::LINK_NULL);
				if (!have) have = add_block();
				if (have && head != sfla_pkg::LINK_NULL) begin
					r.ok = 1'b1;
					r.granted_slot = head[SW-1:0];
					head = next_link[head[SW-1:0]];
					if (free_cnt != 0) free_cnt--;
					held_slots.push_back(int'(r.granted_slot));
				end
			end else if (it.slot_null) begin
				r.ok = 1'b1;
			end else if ({1'b0, it.slot} < cap_cnt) begin
				next_link[it.slot] = head;
				head = {1'b0, it.slot};
				if (free_cnt != sfla_pkg::COUNT_MAX) free_cnt++;
				r.ok = 1'b1;
			end
			r.free_slots  = free_cnt;
			r.total_slots = cap_cnt;
			r.blocks_used = blk_cnt;
			return r;
		endfunction

		function void note_item(sfla_pkg::sfla_in_t it);
			awaited_results.push_back(step_free_list(it));
		endfunction

		function void diff_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(sfla_pkg::sfla_out_t got);
			sfla_pkg::sfla_out_t want;
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: result with none awaited, expected none got %h", $time, got);
				return;
			end
			want = awaited_results.pop_front();
			diff_field("ok", CW'(want.ok), CW'(got.ok));
			diff_field("granted_slot", CW'(want.granted_slot), CW'(got.granted_slot));
			diff_field("free_slots", want.free_slots, got.free_slots);
			diff_field("total_slots", want.total_slots, got.total_slots);
			diff_field("blocks_used", want.blocks_used, got.blocks_used);
		endfunction
	endclass

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	sfla_pkg::sfla_in_t            in_data  = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	sfla_pkg::sfla_out_t           out_data;
	logic                          psel    = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite  = 1'b0;
	logic [sfla_pkg::ADDR_W-1:0]   paddr   = '0;
	logic [sfla_pkg::DATA_W-1:0]   pwdata  = '0;
	logic [sfla_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	// steady: neither side idles; hold_req: receiver does one long hold-off
	bit                steady   = 1'b0;
	bit                hold_req = 1'b0;
	int                cycles   = 0;
	slab_scoreboard    sb;

	slab_free_list_allocator_core uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random stalls, or one long hold-off counted here
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// every accepted result transaction goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result(out_data);
	end

	// offer one transaction, maybe after an idle gap, and hold it until accepted
	task automatic send_item(input sfla_pkg::sfla_in_t it);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
	endtask

	task automatic post(input logic op, input int slot, input logic slot_null);
		sfla_pkg::sfla_in_t it;
		it.op        = op;
		it.slot      = SW'(slot);
		it.slot_null = slot_null;
		send_item(it);
	endtask

	// wait until every owed result is back, plus a margin
	task automatic drain();
		while (sb.awaited_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// apb write: setup cycle, access cycle, done when pready is seen high
	task automatic write_reg(input logic idx, input logic [CW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= sfla_pkg::DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	// registers only change with the block idle
	task automatic set_config(input logic [CW-1:0] grow_by, input logic [CW-1:0] limit);
		in_valid <= 1'b0;
		drain();
		write_reg(sfla_pkg::REG_BLOCK_SLOTS, grow_by);
		write_reg(sfla_pkg::REG_MAX_BLOCKS, limit);
	endtask

	// boundaries of the free range, ignored fields, lifo order
	task automatic run_directed();
		post(sfla_pkg::OP_FREE, 0, 1'b0);          // free with no capacity yet: rejected
		post(sfla_pkg::OP_FREE, SLOT_MAX, 1'b1);   // null free on an empty pool
		post(sfla_pkg::OP_ALLOC, SLOT_MAX, 1'b1);  // first alloc grows a block, slot/null ignored
		post(sfla_pkg::OP_FREE, 15, 1'b0);         // top slot of the block
		post(sfla_pkg::OP_FREE, 16, 1'b0);         // exactly total_slots: rejected
		post(sfla_pkg::OP_FREE, SLOT_MAX, 1'b0);   // largest index: rejected
		post(sfla_pkg::OP_ALLOC, 0, 1'b0);
		post(sfla_pkg::OP_ALLOC, 0, 1'b0);
		post(sfla_pkg::OP_ALLOC, 0, 1'b0);
		post(sfla_pkg::OP_ALLOC, 0, 1'b0);
		post(sfla_pkg::OP_FREE, 13, 1'b0);
		post(sfla_pkg::OP_FREE, 12, 1'b0);
		post(sfla_pkg::OP_ALLOC, 0, 1'b0);         // last freed comes back first
		post(sfla_pkg::OP_ALLOC, 0, 1'b0);
		post(sfla_pkg::OP_FREE, 0, 1'b1);          // null free with an in-range slot
		post(sfla_pkg::OP_ALLOC, 512, 1'b0);
		// directed frees bypassed the held list, so forget it rather than double free later
		sb.held_slots.delete();
	endtask

	// mostly alloc and free of held slots, some null and out-of-range frees
	task automatic run_mix(input int count, input int alloc_pct);
		sfla_pkg::sfla_in_t it;
		int roll;
		int pick;
		for (int k = 0; k < count; k++) begin
			roll         = $urandom_range(0, 99);
			it.op        = sfla_pkg::OP_FREE;
			it.slot      = SW'($urandom_range(0, SLOT_MAX));
			it.slot_null = 1'b0;
			if (roll < alloc_pct) begin
				it.op        = sfla_pkg::OP_ALLOC;
				it.slot_null = 1'($urandom_range(0, 1));
			end else if (roll < alloc_pct + 6) begin
				it.slot_null = 1'b1;
			end else if (roll < alloc_pct + 16) begin
				// stray free above capacity; with a full pool none exists, send a null free
				if (int'(sb.cap_cnt) <= SLOT_MAX) begin
					it.slot = SW'($urandom_range(int'(sb.cap_cnt), SLOT_MAX));
				end else begin
					it.slot_null = 1'b1;
				end
			end else if (sb.held_slots.size() != 0) begin
				pick    = $urandom_range(0, sb.held_slots.size() - 1);
				it.slot = SW'(sb.held_slots[pick]);
				sb.held_slots.delete(pick);
			end else begin
				it.op        = sfla_pkg::OP_ALLOC;
				it.slot_null = 1'($urandom_range(0, 1));
			end
			send_item(it);
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// zero block size grows one slot at a time; low block limit runs out fast
		set_config(11'd0, 11'd4);
		run_mix(150, 70);

		// long receiver hold-off while transactions keep coming
		set_config(11'd7, 11'd20);
		hold_req = 1'b1;
		run_mix(250, 55);

		// no idling on either side
		set_config(11'd1, 11'd1024);
		steady = 1'b1;
		run_mix(250, 50);
		steady = 1'b0;

		set_config(11'd300, 11'd1024);
		run_mix(250, 75);

		// no blocks allowed at all
		set_config(11'd1024, 11'd0);
		run_mix(150, 60);

		// full-size block never fits next to existing capacity
		set_config(11'd1024, 11'd1024);
		run_mix(200, 60);

		in_valid <= 1'b0;
		drain();
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
